[rtl/core/rlpsd_pkg.sv]
// ---------------------------------------------------------------------------
// RLP stream decoder package
// Shared types, sizes and codes for the RLP stream decoder core.
// ---------------------------------------------------------------------------
package rlpsd_pkg;

   // Sizing
   localparam int MAX_DEPTH = 16;
   localparam int LEN_BYTES = 4;
   localparam int OFS_W     = 32;
   localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int XW        = ((OFS_W > 32) ? OFS_W : 32) + 2;
   localparam int QDEPTH    = 2;

   // Byte roles
   localparam logic [1:0] ROLE_PREFIX  = 2'd0;
   localparam logic [1:0] ROLE_LENGTH  = 2'd1;
   localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
   localparam logic [1:0] ROLE_IGNORED = 2'd3;

   // Header kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_STRING = 2'd1;
   localparam logic [1:0] KIND_LIST   = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TOO_DEEP  = 3'd1;
   localparam logic [2:0] ERR_TOO_LARGE = 3'd2;
   localparam logic [2:0] ERR_OVERRUN   = 3'd3;
   localparam logic [2:0] ERR_TRUNCATED = 3'd4;

   // Prefix classes
   typedef enum logic [1:0] {
      CLS_SINGLE     = 2'd0,
      CLS_SHORT_STR  = 2'd1,
      CLS_LONG       = 2'd2,
      CLS_SHORT_LIST = 2'd3
   } cls_type;

   // Parse phases
   typedef enum logic [2:0] {
      PH_PREFIX  = 3'b001,
      PH_LENGTH  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic [1:0]  byte_role;
      logic [4:0]  nest_level;
      logic [1:0]  header_kind;
      logic [31:0] item_length;
      logic        string_end;
      logic [4:0]  lists_closed;
      logic [2:0]  error_code;
      logic        frame_last;
   } rsp_type;

   // Classified byte as queued between front and back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       frame_end;
      cls_type    cls;
      logic [6:0] short_len;
      logic [3:0] n_len;
      logic       long_list;
      logic       long_too_many;
   } item_type;

endpackage

[rtl/core/rlpsd_front.sv]
// ---------------------------------------------------------------------------
// RLP decoder front end
// Accepts request transactions and classifies the prefix class of each byte.
// ---------------------------------------------------------------------------
module rlpsd_front (
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rlpsd_pkg::req_type   req_data,
   output logic                 push,
   output rlpsd_pkg::item_type  push_item,
   input  logic                 q_full
);

   logic [7:0] b;
   logic [3:0] n_len;

   assign b         = req_data.data_byte;
   assign req_ready = !q_full && !reset;
   assign push      = req_valid && req_ready;

   // Count of length bytes for the long forms
   assign n_len = (b <= 8'hbf) ? 4'(b - 8'hb7) : 4'(b - 8'hf7);

   // Classify prefix
   always_comb begin
      push_item.data_byte     = b;
      push_item.frame_start   = req_data.frame_start;
      push_item.frame_end     = req_data.frame_end;
      push_item.n_len         = n_len;
      push_item.long_list     = (b >= 8'hf8);
      push_item.long_too_many = (32'(n_len) > 32'(rlpsd_pkg::LEN_BYTES));
      if (b < 8'h80) begin
         push_item.cls       = rlpsd_pkg::CLS_SINGLE;
         push_item.short_len = 7'd0;
      end else if (b <= 8'hb7) begin
         push_item.cls       = rlpsd_pkg::CLS_SHORT_STR;
         push_item.short_len = 7'(b - 8'h80);
      end else if (b <= 8'hbf || b >= 8'hf8) begin
         push_item.cls       = rlpsd_pkg::CLS_LONG;
         push_item.short_len = 7'd0;
      end else begin
         push_item.cls       = rlpsd_pkg::CLS_SHORT_LIST;
         push_item.short_len = 7'(b - 8'hc0);
      end
   end

endmodule

[rtl/core/rlpsd_queue.sv]
// ---------------------------------------------------------------------------
// RLP decoder item queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module rlpsd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rlpsd_pkg::item_type  push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output rlpsd_pkg::item_type  head_item
);

   localparam int CW = $clog2(rlpsd_pkg::QDEPTH + 1);
   localparam int PW = (rlpsd_pkg::QDEPTH > 1) ? $clog2(rlpsd_pkg::QDEPTH) : 1;

   rlpsd_pkg::item_type mem_ff [rlpsd_pkg::QDEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == CW'(rlpsd_pkg::QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = mem_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (32'(wr_ff) == rlpsd_pkg::QDEPTH - 1) ? '0 : PW'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (32'(rd_ff) == rlpsd_pkg::QDEPTH - 1) ? '0 : PW'(rd_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/rlpsd_back.sv]
// ---------------------------------------------------------------------------
// RLP decoder back end
// Runs the parse state, the list end stack and the response register.
// ---------------------------------------------------------------------------
module rlpsd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  rlpsd_pkg::item_type  head_item,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rlpsd_pkg::rsp_type   rsp_data
);

   localparam int OW  = rlpsd_pkg::OFS_W;
   localparam int LW  = rlpsd_pkg::LVL_W;
   localparam int IW  = rlpsd_pkg::IDX_W;
   localparam int XW  = rlpsd_pkg::XW;
   localparam int MD  = rlpsd_pkg::MAX_DEPTH;

   // Parse state
   logic [OW-1:0]        ofs_ff, ofs_in;
   logic [OW-1:0]        stk_ff [MD];
   logic [LW-1:0]        lvl_ff, lvl_in;
   rlpsd_pkg::phase_type ph_ff, ph_in;
   logic [3:0]           left_ff, left_in;
   logic [31:0]          acc_ff, acc_in;
   logic                 plist_ff, plist_in;
   logic [OW-1:0]        send_ff, send_in;
   logic [2:0]           err_ff, err_in;
   logic                 rv_ff, rv_in;
   rlpsd_pkg::rsp_type   rsp_ff, rsp_in;

   // Working values
   logic [OW-1:0]        e_ofs, p, nxt, str_end, top, open_end;
   logic [LW-1:0]        e_lvl, pops;
   rlpsd_pkg::phase_type e_ph;
   logic [3:0]           e_left, left_dec;
   logic [31:0]          e_acc, open_len;
   logic                 e_plist, do_open, open_list, push_stk;
   logic [2:0]           e_err, err;
   logic [XW-1:0]        end_full;
   logic [MD-1:0]        hit;
   logic [7:0]           b;
   logic [1:0]           role, kind;
   logic [31:0]          len;
   logic                 snd;
   logic [LW:0]          closed;

   assign pop       = head_valid && (!rv_ff || rsp_ready);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
   assign b         = head_item.data_byte;

   // Frame start clears the state in front of its byte
   always_comb begin
      if (head_item.frame_start) begin
         e_ofs   = '0;
         e_lvl   = '0;
         e_ph    = rlpsd_pkg::PH_PREFIX;
         e_left  = '0;
         e_acc   = '0;
         e_plist = 1'b0;
         str_end = '0;
         e_err   = rlpsd_pkg::ERR_NONE;
      end else begin
         e_ofs   = ofs_ff;
         e_lvl   = lvl_ff;
         e_ph    = ph_ff;
         e_left  = left_ff;
         e_acc   = acc_ff;
         e_plist = plist_ff;
         str_end = send_ff;
         e_err   = err_ff;
      end
   end

   assign p        = e_ofs;
   assign nxt      = OW'(e_ofs + 1'b1);
   assign top      = stk_ff[IW'(LW'(e_lvl - 1'b1))];
   assign left_dec = 4'(e_left - 1'b1);

   // Compare every open list end with the next offset
   always_comb begin
      for (int i = 0; i < MD; i++) begin
         hit[i] = (32'(i) < 32'(e_lvl)) && (stk_ff[i] == nxt);
      end
   end
   assign pops = LW'($countones(hit));

   // Decode the byte against the parse phase
   always_comb begin
      ph_in     = e_ph;
      left_in   = e_left;
      acc_in    = e_acc;
      plist_in  = e_plist;
      send_in   = str_end;
      role      = rlpsd_pkg::ROLE_PREFIX;
      kind      = rlpsd_pkg::KIND_NONE;
      len       = '0;
      snd       = 1'b0;
      closed    = '0;
      err       = rlpsd_pkg::ERR_NONE;
      do_open   = 1'b0;
      open_len  = '0;
      open_list = 1'b0;
      push_stk  = 1'b0;
      end_full  = '0;
      open_end  = '0;
      unique case (e_ph)
         rlpsd_pkg::PH_PREFIX: begin
            role = rlpsd_pkg::ROLE_PREFIX;
            case (head_item.cls)
               rlpsd_pkg::CLS_SINGLE: begin
                  kind = rlpsd_pkg::KIND_STRING;
                  len  = 32'd1;
                  snd  = 1'b1;
               end
               rlpsd_pkg::CLS_SHORT_STR: begin
                  kind     = rlpsd_pkg::KIND_STRING;
                  len      = 32'(head_item.short_len);
                  do_open  = 1'b1;
                  open_len = 32'(head_item.short_len);
               end
               rlpsd_pkg::CLS_SHORT_LIST: begin
                  kind      = rlpsd_pkg::KIND_LIST;
                  len       = 32'(head_item.short_len);
                  do_open   = 1'b1;
                  open_len  = 32'(head_item.short_len);
                  open_list = 1'b1;
               end
               default: begin
                  if (head_item.long_too_many) begin
                     err = rlpsd_pkg::ERR_TOO_LARGE;
                  end else begin
                     ph_in    = rlpsd_pkg::PH_LENGTH;
                     left_in  = head_item.n_len;
                     acc_in   = '0;
                     plist_in = head_item.long_list;
                  end
               end
            endcase
         end
         rlpsd_pkg::PH_LENGTH: begin
            role = rlpsd_pkg::ROLE_LENGTH;
            if (e_acc[31:24] != 8'd0) begin
               err = rlpsd_pkg::ERR_TOO_LARGE;
            end else begin
               acc_in  = {e_acc[23:0], b};
               left_in = left_dec;
               if (left_dec == 4'd0) begin
                  ph_in     = rlpsd_pkg::PH_PREFIX;
                  kind      = e_plist ? rlpsd_pkg::KIND_LIST : rlpsd_pkg::KIND_STRING;
                  len       = {e_acc[23:0], b};
                  do_open   = 1'b1;
                  open_len  = {e_acc[23:0], b};
                  open_list = e_plist;
               end
            end
         end
         rlpsd_pkg::PH_PAYLOAD: begin
            role = rlpsd_pkg::ROLE_PAYLOAD;
            if (nxt == str_end) begin
               snd   = 1'b1;
               ph_in = rlpsd_pkg::PH_PREFIX;
            end
         end
         default: begin
            role = rlpsd_pkg::ROLE_PREFIX;
         end
      endcase

      // Open an item whose payload follows this byte
      if (do_open) begin
         end_full = XW'(p) + XW'(1) + XW'(open_len);
         open_end = end_full[OW-1:0];
         if (end_full[XW-1:OW] != '0) begin
            err = rlpsd_pkg::ERR_TOO_LARGE;
         end else if (e_lvl != '0 && open_end > top) begin
            err = rlpsd_pkg::ERR_OVERRUN;
         end else if (open_len == 32'd0) begin
            if (open_list) begin
               closed = (LW + 1)'(1);
            end else begin
               snd = 1'b1;
            end
         end else if (open_list) begin
            if (32'(e_lvl) >= MD) begin
               err = rlpsd_pkg::ERR_TOO_DEEP;
            end else begin
               push_stk = 1'b1;
            end
         end else begin
            ph_in   = rlpsd_pkg::PH_PAYLOAD;
            send_in = open_end;
         end
      end

      // Close lists and check the frame end
      lvl_in = e_lvl;
      if (err == rlpsd_pkg::ERR_NONE && ph_in != rlpsd_pkg::PH_PREFIX && !push_stk &&
          e_lvl != '0 && top == nxt) begin
         err = rlpsd_pkg::ERR_OVERRUN;
      end
      if (err == rlpsd_pkg::ERR_NONE) begin
         lvl_in = push_stk ? LW'(e_lvl + 1'b1) : LW'(e_lvl - pops);
         closed = closed + (LW + 1)'(push_stk ? '0 : pops);
         if (head_item.frame_end &&
             (ph_in != rlpsd_pkg::PH_PREFIX || lvl_in != '0)) begin
            err = rlpsd_pkg::ERR_TRUNCATED;
         end
      end
      if (err != rlpsd_pkg::ERR_NONE) begin
         kind   = rlpsd_pkg::KIND_NONE;
         len    = '0;
         snd    = 1'b0;
         closed = '0;
      end
   end

   // Build the response
   always_comb begin
      ofs_in = pop ? nxt : ofs_ff;
      err_in = err_ff;
      rv_in  = rv_ff;
      rsp_in = rsp_ff;
      if (rsp_ready) begin
         rv_in = 1'b0;
      end
      if (pop) begin
         rv_in                = 1'b1;
         rsp_in.byte_out      = b;
         rsp_in.frame_last    = head_item.frame_end;
         if (e_err != rlpsd_pkg::ERR_NONE) begin
            rsp_in.byte_role    = rlpsd_pkg::ROLE_IGNORED;
            rsp_in.nest_level   = '0;
            rsp_in.header_kind  = rlpsd_pkg::KIND_NONE;
            rsp_in.item_length  = '0;
            rsp_in.string_end   = 1'b0;
            rsp_in.lists_closed = '0;
            rsp_in.error_code   = e_err;
            err_in              = e_err;
         end else begin
            rsp_in.byte_role    = role;
            rsp_in.nest_level   = 5'(e_lvl);
            rsp_in.header_kind  = kind;
            rsp_in.item_length  = len;
            rsp_in.string_end   = snd;
            rsp_in.lists_closed = 5'(closed);
            rsp_in.error_code   = err;
            err_in              = err;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_ff   <= '0;
         lvl_ff   <= '0;
         ph_ff    <= rlpsd_pkg::PH_PREFIX;
         left_ff  <= '0;
         acc_ff   <= '0;
         plist_ff <= 1'b0;
         send_ff  <= '0;
         err_ff   <= rlpsd_pkg::ERR_NONE;
         rv_ff    <= 1'b0;
      end else begin
         ofs_ff <= ofs_in;
         err_ff <= err_in;
         rv_ff  <= rv_in;
         if (pop && e_err == rlpsd_pkg::ERR_NONE) begin
            lvl_ff   <= lvl_in;
            ph_ff    <= ph_in;
            left_ff  <= left_in;
            acc_ff   <= acc_in;
            plist_ff <= plist_in;
            send_ff  <= send_in;
         end else if (pop) begin
            lvl_ff <= e_lvl;
            ph_ff  <= e_ph;
         end
      end
   end

   // Payload registers and stack write
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (pop && e_err == rlpsd_pkg::ERR_NONE && push_stk && err == rlpsd_pkg::ERR_NONE) begin
         stk_ff[IW'(e_lvl)] <= open_end;
      end
   end

endmodule

[rtl/core/rlp_stream_decoder_core.sv]
// ---------------------------------------------------------------------------
// RLP stream decoder core
// Parses an RLP byte stream, one byte per transaction, and tags each byte.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_data (data_byte, frames)
//   rsp      out        rsp_valid/rsp_ready    rsp_data (role, depth, lengths)
//
// One byte per cycle sustained while the response is not stalled; each byte
// passes through a queue entry and then the response register.
// The back end updates the parse state and list end stack together per byte,
// comparing all open list ends against the next offset in parallel.
// Reset clears the parse state; stack entries are only read below the level.
// A stalled response holds the back end; the two-entry queue absorbs one
// extra byte before req_ready drops.
// ---------------------------------------------------------------------------
module rlp_stream_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rlpsd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rlpsd_pkg::rsp_type rsp_data
);

   logic                push, pop, q_full, head_valid;
   rlpsd_pkg::item_type push_item, head_item;

   rlpsd_front u_front (
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full)
   );

   rlpsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   rlpsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/core/rlpsd_checker.sv]
// ---------------------------------------------------------------------------
// RLP decoder port checker
// Checks response behavior seen on the top level ports.
// ---------------------------------------------------------------------------
module rlpsd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rlpsd_pkg::rsp_type rsp_data
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // Drop response valid after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Error transactions carry no header or closes
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != rlpsd_pkg::ERR_NONE |->
      rsp_data.header_kind == rlpsd_pkg::KIND_NONE && rsp_data.lists_closed == 5'd0 &&
      rsp_data.string_end == 1'b0)
      else $error("error transaction with parse results");

   // Ignored bytes repeat a nonzero error
   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_role == rlpsd_pkg::ROLE_IGNORED |->
      rsp_data.error_code != rlpsd_pkg::ERR_NONE && rsp_data.nest_level == 5'd0)
      else $error("ignored byte without sticky error");

endmodule

bind rlp_stream_decoder_core rlpsd_checker u_rlpsd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
